>>> hdl/mhpq_pkg.sv
// mhpq_pkg: shared types and constants of the min-heap priority queue
// no dependencies; used by the channel interfaces and the top level

package mhpq_pkg;

	localparam int KEY_W    = 16;
	localparam int PAY_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int CAP_W    = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic MODE_INSERT  = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_I_CHK,
		S_I_CMP,
		S_X_LOAD,
		S_X_CHK,
		S_X_CMP,
		S_RES
	} state_t;

endpackage

>>> hdl/mhpq_if.sv
// mhpq_req_if, mhpq_rsp_if: valid/ready channels of the heap queue
// depends on mhpq_pkg for field widths

interface mhpq_req_if;
	import mhpq_pkg::*;
	logic             valid;
	logic             ready;
	logic             mode;
	logic [KEY_W-1:0] key;
	logic [PAY_W-1:0] payload;

	modport source (output valid, output mode, output key, output payload, input ready);
	modport sink   (input valid, input mode, input key, input payload, output ready);
endinterface

interface mhpq_rsp_if;
	import mhpq_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    out_key;
	logic [PAY_W-1:0]    out_payload;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, output status, output out_key, output out_payload,
		output count, input ready);
	modport sink   (input valid, input status, input out_key, input out_payload,
		input count, output ready);
endinterface

>>> hdl/min_heap_priority_queue_top.sv
// min_heap_priority_queue_top: binary min-heap with one shared compare step per cycle
// insert: check, sift-up, finish; extract: root load, check, sift-down, finish; full or empty
// beats go straight to finish; one item in flight, next beat taken on return to idle
// the single-write, dual-read heap memory sets one tree level per cycle
// reset (arst_n low): count 0, capacity 64, no result pending; heap contents are not cleared
// depends on mhpq_pkg and mhpq_if

module min_heap_priority_queue_top #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mhpq_req_if.sink                   req,
	mhpq_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [mhpq_pkg::CAP_W-1:0] cfg_wdata
);
	import mhpq_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int PW   = $clog2(DEPTH + 1);
	localparam int EW   = KEY_BITS + PAY_W;
	localparam int CMPW = (PW > CAP_W) ? PW : CAP_W;

	logic [EW-1:0] mem [DEPTH];

	state_t               state_q, state_d;
	logic [PW-1:0]        count_q, pos_q, n_q;
	logic [CAP_W-1:0]     cap_q;
	logic [EW-1:0]        x_q, rd_a_q, rd_b_q;
	status_t              st_q;
	logic [KEY_BITS-1:0]  rk_q;
	logic [PAY_W-1:0]     rp_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [KEY_W-1:0]     out_key_q;
	logic [PAY_W-1:0]     out_pay_q;
	logic [COUNT_W-1:0]   out_count_q;

	logic                 mem_we, ra_en, rb_en;
	logic [AW-1:0]        mem_wa, ra_addr, rb_addr;
	logic [EW-1:0]        mem_wd;

	logic                 req_fire, out_free, full;
	logic [CMPW-1:0]      capw, depw, cap_eff;
	logic [KEY_BITS-1:0]  key_x, key_a, key_b;
	logic [PW-1:0]        par, gpar, jc_p;
	logic [PW:0]          jw, nw, jc_w, gjw;
	logic                 has_l, has_r, right_sel, ins_lt, x_gt, has_gl;
	logic [EW-1:0]        child;

	assign req_fire = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign capw    = CMPW'(cap_q);
	assign depw    = CMPW'(DEPTH);
	assign cap_eff = (capw > depw) ? depw : capw;
	assign full    = CMPW'(count_q) >= cap_eff;

	// shared compare unit operands
	assign key_x = x_q[EW-1 -: KEY_BITS];
	assign key_a = rd_a_q[EW-1 -: KEY_BITS];
	assign key_b = rd_b_q[EW-1 -: KEY_BITS];

	assign par  = pos_q >> 1;
	assign gpar = par >> 1;
	assign ins_lt = key_x < key_a;

	assign jw    = {pos_q, 1'b0};
	assign nw    = {1'b0, n_q};
	assign has_l = jw <= nw;
	assign has_r = (jw + 1'b1) <= nw;
	assign right_sel = has_r && (key_b < key_a);
	assign child = right_sel ? rd_b_q : rd_a_q;
	assign jc_w  = right_sel ? (jw + 1'b1) : jw;
	assign jc_p  = PW'(jc_w);
	assign x_gt  = key_x > child[EW-1 -: KEY_BITS];
	assign gjw   = {jc_p, 1'b0};
	assign has_gl = gjw <= nw;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.mode == MODE_INSERT)
						state_d = full ? S_RES : S_I_CHK;
					else
						state_d = (count_q == '0) ? S_RES : S_X_LOAD;
				end
			end
			S_I_CHK:  state_d = (pos_q == PW'(1)) ? S_RES : S_I_CMP;
			S_I_CMP:  state_d = (ins_lt && par != PW'(1)) ? S_I_CMP : S_RES;
			S_X_LOAD: state_d = S_X_CHK;
			S_X_CHK:  state_d = has_l ? S_X_CMP : S_RES;
			S_X_CMP:  state_d = (x_gt && has_gl) ? S_X_CMP : S_RES;
			S_RES:    state_d = out_free ? S_IDLE : S_RES;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = x_q;
		ra_en   = 1'b0;
		ra_addr = '0;
		rb_en   = 1'b0;
		rb_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (req_fire && req.mode == MODE_EXTRACT && count_q != '0) begin
					ra_en   = 1'b1;
					rb_en   = 1'b1;
					rb_addr = AW'(count_q - 1'b1);
				end
			end
			S_I_CHK: begin
				if (pos_q != PW'(1)) begin
					ra_en   = 1'b1;
					ra_addr = AW'(par - 1'b1);
				end
			end
			S_I_CMP: begin
				if (ins_lt) begin
					mem_we = 1'b1;
					mem_wa = AW'(pos_q - 1'b1);
					mem_wd = rd_a_q;
					if (par != PW'(1)) begin
						ra_en   = 1'b1;
						ra_addr = AW'(gpar - 1'b1);
					end
				end
			end
			S_X_CHK: begin
				if (has_l) begin
					ra_en   = 1'b1;
					ra_addr = AW'(jw - 1'b1);
					rb_en   = 1'b1;
					rb_addr = AW'(jw);
				end
			end
			S_X_CMP: begin
				if (x_gt) begin
					mem_we = 1'b1;
					mem_wa = AW'(pos_q - 1'b1);
					mem_wd = child;
					if (has_gl) begin
						ra_en   = 1'b1;
						ra_addr = AW'(gjw - 1'b1);
						rb_en   = 1'b1;
						rb_addr = AW'(gjw);
					end
				end
			end
			S_RES: begin
				if (out_free && st_q == STAT_OK) begin
					mem_we = 1'b1;
					mem_wa = AW'(pos_q - 1'b1);
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (ra_en)
			rd_a_q <= mem[ra_addr];
		if (rb_en)
			rd_b_q <= mem[rb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					x_q  <= {KEY_BITS'(req.key), req.payload};
					rk_q <= '0;
					rp_q <= '0;
					if (req.mode == MODE_INSERT) begin
						if (full) begin
							st_q <= STAT_FULL;
							n_q  <= count_q;
						end else begin
							st_q  <= STAT_OK;
							n_q   <= PW'(count_q + 1'b1);
							pos_q <= PW'(count_q + 1'b1);
						end
					end else if (count_q == '0) begin
						st_q <= STAT_EMPTY;
						n_q  <= '0;
					end else begin
						st_q <= STAT_OK;
						n_q  <= PW'(count_q - 1'b1);
					end
				end
			end
			S_I_CMP: begin
				if (ins_lt)
					pos_q <= par;
			end
			S_X_LOAD: begin
				rk_q  <= key_a;
				rp_q  <= rd_a_q[PAY_W-1:0];
				x_q   <= rd_b_q;
				pos_q <= PW'(1);
			end
			S_X_CMP: begin
				if (x_gt)
					pos_q <= jc_p;
			end
			default: begin
				rk_q <= rk_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			if (state_q == S_RES && out_free) begin
				out_valid_q <= 1'b1;
				count_q     <= n_q;
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (state_q == S_RES && out_free) begin
			out_status_q <= st_q;
			out_key_q    <= KEY_W'(rk_q);
			out_pay_q    <= rp_q;
			out_count_q  <= COUNT_W'(n_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.out_key     = out_key_q;
	assign rsp.out_payload = out_pay_q;
	assign rsp.count       = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PW'(DEPTH))
		else $error("heap count above depth");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_I_CMP || state_q == S_X_CMP || state_q == S_RES))
		else $error("heap write outside a sift or finish step");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != S_IDLE)
		else $error("accepted beat did not start work");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RES)
		else $error("result beat raised outside finish step");

	a_load_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_X_LOAD |-> $past(state_q) == S_IDLE)
		else $error("root load not preceded by accept");

endmodule

>>> tb/testbench.sv
// testbench: checks min_heap_priority_queue_top against its own heap predictor, beat by beat
// depends on mhpq_pkg, mhpq_req_if/mhpq_rsp_if and the top level in hdl
// random traffic under several idle/stall mixes, capacity changes, a full-depth fill and a long stall

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mhpq_pkg::*;

	localparam int DEPTH         = 64;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_GAP       = 60;

	typedef struct {
		status_t            status;
		logic [KEY_W-1:0]   out_key;
		logic [PAY_W-1:0]   out_payload;
		logic [COUNT_W-1:0] count;
	} heap_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	mhpq_req_if req_ch ();
	mhpq_rsp_if rsp_ch ();

	min_heap_priority_queue_top #(.DEPTH(DEPTH), .KEY_BITS(KEY_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predicted heap contents
	logic [KEY_W-1:0] heap_key [1:DEPTH];
	logic [PAY_W-1:0] heap_pay [1:DEPTH];
	int heap_count = 0;
	int cap_reg = CAP_RESET;
	heap_result_t pending_results[$];

	int items_accepted = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int n_insert = 0;
	int n_extract = 0;
	int n_full = 0;
	int n_empty = 0;
	int peak_count = 0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				items_accepted - results_seen);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic apply_heap_op(input logic op, input logic [KEY_W-1:0] k,
		input logic [PAY_W-1:0] p, output heap_result_t r);
		int eff_cap;
		int i;
		int j;
		int n;
		logic [KEY_W-1:0] tk;
		logic [PAY_W-1:0] tp;
		eff_cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		r.status = STAT_OK;
		r.out_key = '0;
		r.out_payload = '0;
		if (op == MODE_INSERT) begin
			if (heap_count >= eff_cap) begin
				r.status = STAT_FULL;
			end else begin
				i = heap_count + 1;
				while (i > 1 && k < heap_key[i / 2]) begin
					heap_key[i] = heap_key[i / 2];
					heap_pay[i] = heap_pay[i / 2];
					i = i / 2;
				end
				heap_key[i] = k;
				heap_pay[i] = p;
				heap_count++;
			end
		end else if (heap_count == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			n = heap_count;
			r.out_key = heap_key[1];
			r.out_payload = heap_pay[1];
			heap_key[1] = heap_key[n];
			heap_pay[1] = heap_pay[n];
			n--;
			i = 1;
			j = 2;
			while (j <= n) begin
				if (j + 1 <= n && heap_key[j + 1] < heap_key[j])
					j++;
				if (heap_key[i] > heap_key[j]) begin
					tk = heap_key[i];
					tp = heap_pay[i];
					heap_key[i] = heap_key[j];
					heap_pay[i] = heap_pay[j];
					heap_key[j] = tk;
					heap_pay[j] = tp;
					i = j;
					j = 2 * i;
				end else begin
					break;
				end
			end
			heap_count = n;
		end
		r.count = COUNT_W'(heap_count);
	endtask

	// result check first, then the accepted request, so order within one edge is fixed
	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					note_failure($sformatf("unexpected beat: status %0d key %h payload %h count %0d",
						rsp_ch.status, rsp_ch.out_key, rsp_ch.out_payload, rsp_ch.count));
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.status !== want.status || rsp_ch.out_key !== want.out_key ||
						rsp_ch.out_payload !== want.out_payload || rsp_ch.count !== want.count)
						note_failure($sformatf({"beat %0d: expected status %0d key %h payload %h",
							" count %0d, got status %0d key %h payload %h count %0d"},
							results_seen, want.status, want.out_key, want.out_payload, want.count,
							rsp_ch.status, rsp_ch.out_key, rsp_ch.out_payload, rsp_ch.count));
					if (want.status == STAT_FULL)
						n_full++;
					if (want.status == STAT_EMPTY)
						n_empty++;
					if (want.count > peak_count)
						peak_count = want.count;
				end
			end
			if (cfg_we)
				cap_reg = cfg_wdata;
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.mode == MODE_INSERT)
					n_insert++;
				else
					n_extract++;
				apply_heap_op(req_ch.mode, req_ch.key, req_ch.payload, want);
				pending_results.push_back(want);
			end
		end
	end

	task automatic offer_op(input logic op, input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= op;
		req_ch.key <= k;
		req_ch.payload <= p;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_accepted++;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_seen < items_accepted)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// many duplicates and extremes so ties and equal-key sifting are exercised
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0: return KEY_W'($urandom_range(7));
			1: begin
				case ($urandom_range(3))
					0: return '0;
					1: return '1;
					2: return 16'h8000;
					default: return 16'h7fff;
				endcase
			end
			default: return KEY_W'($urandom);
		endcase
	endfunction

	task automatic run_random_ops(input int n);
		int left;
		int run;
		int extract_pct;
		left = n;
		run = 0;
		extract_pct = 50;
		while (left > 0) begin
			if (run == 0) begin
				run = $urandom_range(5, 40);
				case ($urandom_range(4))
					0, 1: extract_pct = 25;
					2, 3: extract_pct = 70;
					default: extract_pct = 50;
				endcase
			end
			offer_op(($urandom_range(99) < extract_pct) ? MODE_EXTRACT : MODE_INSERT,
				pick_key(), PAY_W'($urandom));
			run--;
			left--;
		end
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		offer_op(MODE_EXTRACT, 16'h1234, 8'h34);
		offer_op(MODE_INSERT, 16'h0000, 8'h00);
		offer_op(MODE_INSERT, 16'hffff, 8'hff);
		offer_op(MODE_INSERT, 16'h8000, 8'ha5);
		offer_op(MODE_INSERT, 16'h8000, 8'h5a);
		offer_op(MODE_INSERT, 16'h0001, 8'h01);
		repeat (6) offer_op(MODE_EXTRACT, pick_key(), PAY_W'($urandom));
		write_capacity(7'd2);
		repeat (3) offer_op(MODE_INSERT, pick_key(), PAY_W'($urandom));
		// capacity below the count held
		write_capacity(7'd1);
		offer_op(MODE_INSERT, 16'h0002, 8'h22);
		offer_op(MODE_EXTRACT, 16'h0000, 8'h00);
		offer_op(MODE_INSERT, 16'h0003, 8'h33);
		offer_op(MODE_EXTRACT, 16'h0000, 8'h00);
		offer_op(MODE_INSERT, 16'hfffe, 8'hee);
		write_capacity(7'd0);
		offer_op(MODE_INSERT, 16'h0000, 8'h11);
		offer_op(MODE_EXTRACT, 16'h0000, 8'h00);
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		write_capacity(CAP_RESET);
		run_random_ops(350);
		send_idle_pct = 80;
		write_capacity(7'd127);
		run_random_ops(350);
		send_idle_pct = 0;
		rsp_stall_pct = 80;
		write_capacity(CAP_RESET);
		run_random_ops(350);
		send_idle_pct = 14;
		rsp_stall_pct = 14;
		write_capacity(7'd33);
		run_random_ops(350);
	endtask

	task automatic test_capacity_sweep();
		send_idle_pct = 14;
		rsp_stall_pct = 14;
		write_capacity(7'd1);
		run_random_ops(40);
		write_capacity(7'd2);
		run_random_ops(40);
		write_capacity(7'd3);
		run_random_ops(40);
		write_capacity(7'd7);
		run_random_ops(40);
	endtask

	task automatic test_fill_to_depth();
		send_idle_pct = 14;
		rsp_stall_pct = 14;
		write_capacity(7'd0);
		// empty the heap left by earlier traffic without adding to it
		while (heap_count > 0)
			offer_op(MODE_EXTRACT, pick_key(), PAY_W'($urandom));
		write_capacity(7'd127);
		repeat (DEPTH + 2) offer_op(MODE_INSERT, pick_key(), PAY_W'($urandom));
		write_capacity(7'd10);
		repeat (3) offer_op(MODE_INSERT, pick_key(), PAY_W'($urandom));
		repeat (DEPTH + 1) offer_op(MODE_EXTRACT, pick_key(), PAY_W'($urandom));
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		write_capacity(CAP_RESET);
		hold_req++;
		repeat (16)
			offer_op($urandom_range(2) == 0 ? MODE_EXTRACT : MODE_INSERT, pick_key(),
				PAY_W'($urandom));
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_INSERT;
		req_ch.key <= '0;
		req_ch.payload <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic();
		test_capacity_sweep();
		test_fill_to_depth();
		test_backpressure();
		wait_idle();
		if (pending_results.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_results.size()));
		$display("covered %0d inserts and %0d extracts: %0d refused as full, %0d empty answers",
			n_insert, n_extract, n_full, n_empty);
		$display("peak occupancy %0d, %0d mismatches in %0d cycles", peak_count, mismatches, cycles);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
hdl/mhpq_pkg.sv
hdl/mhpq_if.sv
hdl/min_heap_priority_queue_top.sv
tb/testbench.sv
